// ===== src/bfq_pkg.sv =====
// Shared types and codes of the bulk frame queue packetizer.
package bfq_pkg;

    // Field widths fixed by the interface
    localparam int SLOT_W = 2;
    localparam int PEND_W = 3;

    // Input operation codes
    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_EVENT  = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_TX     = 3'd1;
    localparam logic [2:0] KIND_ZLP    = 3'd2;
    localparam logic [2:0] KIND_STORE  = 3'd3;
    localparam logic [2:0] KIND_FLUSH  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    // Transmit buffer load sources
    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_INPUT = 2'd1;
    localparam logic [1:0] SRC_SLOT  = 2'd2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PACKET_SIZE = 2'd0;
    localparam logic [1:0] REG_EP_OPEN     = 2'd1;
    localparam logic [1:0] REG_THR_EN      = 2'd2;
    localparam logic [1:0] REG_THR_INTV    = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] frame_length;
        logic [31:0] now_ms;
        logic        tx_accept;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  status;
        logic [1:0]  load_source;
        logic [1:0]  slot;
        logic [14:0] packet_offset;
        logic [10:0] packet_length;
        logic        frame_done;
        logic [2:0]  pending;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [10:0] packet_size;
        logic        endpoint_open;
        logic        throttle_enable;
        logic [15:0] throttle_interval_ms;
    } t_cfg;

    // Item class decided by the front end
    typedef enum logic [2:0] {
        CMD_SUBMIT,
        CMD_BAD_LEN,
        CMD_EVENT,
        CMD_FLUSH,
        CMD_NOP
    } t_cmd;

    typedef struct packed {
        t_cmd        cls;
        logic [15:0] len;
        logic [31:0] now_ms;
        logic        accept;
    } t_cmd_beat;

endpackage

// ===== src/bfq_front.sv =====
// Front end: accepts input beats, classifies them and queues them for the executor.
module bfq_front #(
    parameter int MAX_FRAME_BYTES = 32768
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfq_pkg::t_item      i_item,
    input  logic                i_push,
    output logic                o_full,
    output bfq_pkg::t_cmd_beat  o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_BYTES);

    bfq_pkg::t_cmd_beat r_buf [2];
    logic               r_wr;
    logic               r_rd;
    logic [1:0]         r_cnt;
    bfq_pkg::t_cmd_beat cls_beat;
    logic               push_fire;
    logic               pop_fire;

    // Classify the incoming beat
    always_comb begin
        cls_beat.len    = i_item.frame_length;
        cls_beat.now_ms = i_item.now_ms;
        cls_beat.accept = i_item.tx_accept;
        case (i_item.op)
            bfq_pkg::OP_SUBMIT: begin
                if (i_item.frame_length == 16'd0 || i_item.frame_length > MAX_LEN) begin
                    cls_beat.cls = bfq_pkg::CMD_BAD_LEN;
                end else begin
                    cls_beat.cls = bfq_pkg::CMD_SUBMIT;
                end
            end
            bfq_pkg::OP_EVENT: cls_beat.cls = bfq_pkg::CMD_EVENT;
            bfq_pkg::OP_FLUSH: cls_beat.cls = bfq_pkg::CMD_FLUSH;
            default:           cls_beat.cls = bfq_pkg::CMD_NOP;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_buf[r_rd];
    assign push_fire   = i_push && !o_full;
    assign pop_fire    = o_cmd_valid && i_cmd_ready;

    // Two-entry command queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_fire) r_wr <= ~r_wr;
            if (pop_fire)  r_rd <= ~r_rd;
            case ({push_fire, pop_fire})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Hold the queued payload
    always_ff @(posedge i_clk) begin
        if (push_fire) r_buf[r_wr] <= cls_beat;
    end

endmodule

// ===== src/bfq_back.sv =====
// Back end: frame scheduler, slot ring, packet cutting and result staging.
module bfq_back #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfq_pkg::t_cfg       i_cfg,
    input  bfq_pkg::t_cmd_beat  i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    output bfq_pkg::t_result    o_result,
    output logic                o_empty,
    input  logic                i_pop
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = bfq_pkg::SLOT_W;
    localparam int PW    = bfq_pkg::PEND_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // Scheduler state
    logic [15:0]       r_slot_len [QUEUE_DEPTH];
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_in_flight, n_in_flight;
    logic [16:0]       r_offset, n_offset;
    logic [15:0]       r_total, n_total;
    logic [31:0]       r_last_time, n_last_time;

    // Result staging
    bfq_pkg::t_result  r_res0, r_res1;
    logic [1:0]        r_res_cnt;

    bfq_pkg::t_result  res [2];
    logic [1:0]        nres;
    logic              wr_en;
    logic              can_load;
    logic              fire;
    logic [15:0]       head_len;
    logic [16:0]       sum;
    logic [15:0]       rem;
    logic [31:0]       elapsed;
    logic              drop;
    logic [CNT_W-1:0]  fill_mid;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  tail_inc;

    function automatic logic [10:0] pkt_min(logic [10:0] ps, logic [16:0] avail);
        if ({6'd0, ps} < avail) return ps;
        return avail[10:0];
    endfunction

    function automatic bfq_pkg::t_result mk_res(logic [2:0] kind, logic [1:0] status,
                                                logic [1:0] src, logic [1:0] slot,
                                                logic [14:0] off, logic [10:0] len,
                                                logic done, logic [2:0] pend);
        bfq_pkg::t_result r;
        r.kind          = kind;
        r.status        = status;
        r.load_source   = src;
        r.slot          = slot;
        r.packet_offset = off;
        r.packet_length = len;
        r.frame_done    = done;
        r.pending       = pend;
        r.last          = 1'b0;
        return r;
    endfunction

    // Result of a frame start: busy when closed, else the first packet
    function automatic bfq_pkg::t_result start_res(logic open, logic acc, logic [1:0] src,
                                                   logic [1:0] slot, logic [15:0] len,
                                                   logic [10:0] ps, logic done);
        if (!open) begin
            return mk_res(bfq_pkg::KIND_STATUS, bfq_pkg::ST_BUSY, bfq_pkg::SRC_NONE,
                          slot, 15'd0, 11'd0, done, 3'd0);
        end
        return mk_res(bfq_pkg::KIND_TX, acc ? bfq_pkg::ST_OK : bfq_pkg::ST_FAIL, src,
                      slot, 15'd0, pkt_min(ps, {1'b0, len}), done, 3'd0);
    endfunction

    assign can_load    = (r_res_cnt == 2'd0) || (r_res_cnt == 2'd1 && i_pop);
    assign o_cmd_ready = can_load;
    assign fire        = i_cmd_valid && can_load;
    assign o_empty     = (r_res_cnt == 2'd0);
    assign o_result    = r_res0;

    assign head_len = r_slot_len[r_head];
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + IDX_W'(1);
    assign sum      = r_offset + {6'd0, i_cfg.packet_size};
    assign rem      = r_total - sum[15:0];
    assign elapsed  = (r_last_time != 32'd0) ? i_cmd.now_ms - r_last_time
                                             : {16'd0, i_cfg.throttle_interval_ms};
    assign drop     = i_cfg.throttle_enable && (elapsed < {16'd0, i_cfg.throttle_interval_ms});

    // Work out one command: next state and up to two results
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_in_flight = r_in_flight;
        n_offset    = r_offset;
        n_total     = r_total;
        n_last_time = r_last_time;
        res[0]      = '0;
        res[1]      = '0;
        nres        = 2'd0;
        wr_en       = 1'b0;
        fill_mid    = r_fill;
        case (i_cmd.cls)
            bfq_pkg::CMD_BAD_LEN: begin
                res[0] = mk_res(bfq_pkg::KIND_STATUS, bfq_pkg::ST_FAIL, bfq_pkg::SRC_NONE,
                                2'd0, 15'd0, 11'd0, 1'b0, 3'd0);
                nres   = 2'd1;
            end
            bfq_pkg::CMD_SUBMIT: begin
                if (i_cfg.throttle_enable && !drop) n_last_time = i_cmd.now_ms;
                if (drop) begin
                    res[0] = mk_res(bfq_pkg::KIND_STATUS, bfq_pkg::ST_OK, bfq_pkg::SRC_NONE,
                                    2'd0, 15'd0, 11'd0, 1'b0, 3'd0);
                    nres   = 2'd1;
                end else if (r_fill == '0 && !r_in_flight) begin
                    // send the frame straight away
                    res[0] = start_res(i_cfg.endpoint_open, i_cmd.accept, bfq_pkg::SRC_INPUT,
                                       2'd0, i_cmd.len, i_cfg.packet_size, 1'b0);
                    nres   = 2'd1;
                    if (i_cfg.endpoint_open) begin
                        n_total     = i_cmd.len;
                        n_offset    = 17'd0;
                        n_in_flight = i_cmd.accept;
                    end
                end else begin
                    // drain the oldest frame first when the endpoint is idle
                    if (r_fill != '0 && !r_in_flight) begin
                        res[0]   = start_res(i_cfg.endpoint_open, i_cmd.accept,
                                             bfq_pkg::SRC_SLOT, SW'(r_head), head_len,
                                             i_cfg.packet_size, 1'b0);
                        nres     = 2'd1;
                        n_head   = head_inc;
                        fill_mid = r_fill - CNT_W'(1);
                        if (i_cfg.endpoint_open) begin
                            n_total     = head_len;
                            n_offset    = 17'd0;
                            n_in_flight = i_cmd.accept;
                        end
                    end
                    if (fill_mid >= FULL_CNT) begin
                        res[nres[0]] = mk_res(bfq_pkg::KIND_STATUS, bfq_pkg::ST_FAIL,
                                              bfq_pkg::SRC_NONE, 2'd0, 15'd0, 11'd0,
                                              1'b0, 3'd0);
                        n_fill       = fill_mid;
                    end else begin
                        res[nres[0]] = mk_res(bfq_pkg::KIND_STORE, bfq_pkg::ST_OK,
                                              bfq_pkg::SRC_NONE, SW'(r_tail), 15'd0, 11'd0,
                                              1'b0, 3'd0);
                        wr_en        = 1'b1;
                        n_tail       = tail_inc;
                        n_fill       = fill_mid + CNT_W'(1);
                    end
                    nres = nres + 2'd1;
                end
            end
            bfq_pkg::CMD_EVENT: begin
                if (r_in_flight) begin
                    n_offset = sum;
                    if (sum < {1'b0, r_total}) begin
                        // advance to the next packet of the frame
                        res[0] = mk_res(bfq_pkg::KIND_TX,
                                        i_cmd.accept ? bfq_pkg::ST_OK : bfq_pkg::ST_FAIL,
                                        bfq_pkg::SRC_NONE, 2'd0, sum[14:0],
                                        pkt_min(i_cfg.packet_size, {1'b0, rem}), 1'b0, 3'd0);
                        nres   = 2'd1;
                        if (!i_cmd.accept) begin
                            n_in_flight = 1'b0;
                            if (r_fill != '0) begin
                                res[1] = start_res(i_cfg.endpoint_open, i_cmd.accept,
                                                   bfq_pkg::SRC_SLOT, SW'(r_head), head_len,
                                                   i_cfg.packet_size, 1'b0);
                                nres   = 2'd2;
                                n_head = head_inc;
                                n_fill = r_fill - CNT_W'(1);
                                if (i_cfg.endpoint_open) begin
                                    n_total     = head_len;
                                    n_offset    = 17'd0;
                                    n_in_flight = i_cmd.accept;
                                end
                            end
                        end
                    end else begin
                        // frame finished: start the next queued one
                        n_in_flight = 1'b0;
                        nres        = 2'd1;
                        if (r_fill != '0) begin
                            res[0] = start_res(i_cfg.endpoint_open, i_cmd.accept,
                                               bfq_pkg::SRC_SLOT, SW'(r_head), head_len,
                                               i_cfg.packet_size, 1'b1);
                            n_head = head_inc;
                            n_fill = r_fill - CNT_W'(1);
                            if (i_cfg.endpoint_open) begin
                                n_total     = head_len;
                                n_offset    = 17'd0;
                                n_in_flight = i_cmd.accept;
                            end
                        end else begin
                            res[0] = mk_res(bfq_pkg::KIND_STATUS, bfq_pkg::ST_OK,
                                            bfq_pkg::SRC_NONE, 2'd0, 15'd0, 11'd0,
                                            1'b1, 3'd0);
                        end
                    end
                end else begin
                    // idle completion: zero-length packet
                    res[0] = mk_res(bfq_pkg::KIND_ZLP,
                                    i_cmd.accept ? bfq_pkg::ST_OK : bfq_pkg::ST_FAIL,
                                    bfq_pkg::SRC_NONE, 2'd0, 15'd0, 11'd0, 1'b0, 3'd0);
                    nres   = 2'd1;
                end
            end
            bfq_pkg::CMD_FLUSH: begin
                res[0]      = mk_res(bfq_pkg::KIND_FLUSH, bfq_pkg::ST_OK, bfq_pkg::SRC_NONE,
                                     2'd0, 15'd0, 11'd0, 1'b0, PW'(r_fill));
                nres        = 2'd1;
                n_head      = '0;
                n_tail      = '0;
                n_fill      = '0;
                n_in_flight = 1'b0;
                n_offset    = 17'd0;
                n_total     = 16'd0;
            end
            default: begin
                nres = 2'd0;
            end
        endcase
        // mark the final result of the item
        if (nres == 2'd1) res[0].last = 1'b1;
        if (nres == 2'd2) res[1].last = 1'b1;
    end

    // Advance scheduler state on each executed command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_in_flight <= 1'b0;
            r_offset    <= 17'd0;
            r_total     <= 16'd0;
            r_last_time <= 32'd0;
        end else if (fire) begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_in_flight <= n_in_flight;
            r_offset    <= n_offset;
            r_total     <= n_total;
            r_last_time <= n_last_time;
        end
    end

    // Store frame lengths into the ring
    always_ff @(posedge i_clk) begin
        if (fire && wr_en) r_slot_len[r_tail] <= i_cmd.len;
    end

    // Stage results and shift them out one beat at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= 2'd0;
        end else if (fire) begin
            r_res_cnt <= nres;
        end else if (i_pop && !o_empty) begin
            r_res_cnt <= r_res_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res0 <= res[0];
            r_res1 <= res[1];
        end else if (i_pop && r_res_cnt == 2'd2) begin
            r_res0 <= r_res1;
        end
    end

endmodule

// ===== src/bulk_frame_queue_packetizer.sv =====
// Top level: configuration registers and the front and back ends.
//
// Bulk IN frame scheduler. A pushed item enters a two-entry command queue; the
// scheduler executes it while it is at the queue head and the result stage can take
// its results, which are registered onto the result port. The scheduler executes
// one item per cycle while the result stage can take it; an item yields zero, one or
// two result beats, and the result stage hands out one beat per cycle while popped.
// A new item is taken into the command queue while results still wait to be popped.
// Registers sit at byte addresses 0 (packet_size), 4 (endpoint_open),
// 8 (throttle_enable) and 12 (throttle_interval_ms); write them only while idle.
module bulk_frame_queue_packetizer #(
    parameter int QUEUE_DEPTH     = 4,
    parameter int MAX_FRAME_BYTES = 32768
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfq_pkg::t_item    i_item,
    input  logic              push,
    output logic              full,
    output bfq_pkg::t_result  o_result,
    output logic              empty,
    input  logic              pop,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    bfq_pkg::t_cfg       r_cfg;
    bfq_pkg::t_cmd_beat  cmd;
    logic                cmd_valid;
    logic                cmd_ready;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.packet_size          <= 11'd512;
            r_cfg.endpoint_open        <= 1'b1;
            r_cfg.throttle_enable      <= 1'b0;
            r_cfg.throttle_interval_ms <= 16'd5000;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                bfq_pkg::REG_PACKET_SIZE: r_cfg.packet_size          <= pwdata[10:0];
                bfq_pkg::REG_EP_OPEN:     r_cfg.endpoint_open        <= pwdata[0];
                bfq_pkg::REG_THR_EN:      r_cfg.throttle_enable      <= pwdata[0];
                bfq_pkg::REG_THR_INTV:    r_cfg.throttle_interval_ms <= pwdata[15:0];
                default:                  r_cfg <= r_cfg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (paddr[3:2])
            bfq_pkg::REG_PACKET_SIZE: prdata = {21'd0, r_cfg.packet_size};
            bfq_pkg::REG_EP_OPEN:     prdata = {31'd0, r_cfg.endpoint_open};
            bfq_pkg::REG_THR_EN:      prdata = {31'd0, r_cfg.throttle_enable};
            bfq_pkg::REG_THR_INTV:    prdata = {16'd0, r_cfg.throttle_interval_ms};
            default:                  prdata = 32'd0;
        endcase
    end

    bfq_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_push      (push),
        .o_full      (full),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    bfq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

// ===== src/bfq_checker.sv =====
// Port-level checks of the packetizer, bound to the top level.
module bfq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input bfq_pkg::t_item    i_item,
    input logic              push,
    input logic              full,
    input bfq_pkg::t_result  o_result,
    input logic              empty,
    input logic              pop,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [3:0]        paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    // Leaving reset: the result queue is empty and the command queue is not full
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // A waiting result beat stays until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result beat dropped without pop");

    // Busy is only ever a status-only answer
    a_busy_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status == bfq_pkg::ST_BUSY) |->
            (o_result.kind == bfq_pkg::KIND_STATUS))
        else $error("busy status on a non-status result");

    // Frame end comes only with a next-frame start or a plain status
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.frame_done) |->
            (o_result.kind == bfq_pkg::KIND_STATUS || o_result.kind == bfq_pkg::KIND_TX))
        else $error("frame_done on an unexpected result kind");

endmodule

bind bulk_frame_queue_packetizer bfq_checker u_bfq_checker (.*);

// ===== bench/bulk_frame_queue_packetizer_tb.sv =====
// Self-checking bench for the bulk frame queue packetizer: directed and random beats.
`timescale 1ns / 100ps

module bulk_frame_queue_packetizer_tb;

    localparam int          QUEUE_DEPTH     = 4;
    localparam int          MAX_FRAME_BYTES = 32768;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          SETTLE_CYCLES   = 10;
    localparam int          LIMIT           = 300000;
    // Operation code the block ignores
    localparam logic [1:0]  OP_UNUSED       = 2'd3;

    // Expected-beat tracker: mirrors the scheduler state and queues its result beats
    class bfq_scoreboard;
        bfq_pkg::t_cfg    cfg;
        logic [15:0]      slot_len [QUEUE_DEPTH];
        logic [1:0]       head;
        logic [1:0]       tail;
        logic [2:0]       fill;
        logic             in_flight;
        logic [16:0]      send_off;
        logic [15:0]      send_len;
        logic [31:0]      last_sent;
        logic             accept_now;
        logic             done_now;
        bfq_pkg::t_result step_beats[$];
        bfq_pkg::t_result expected_beats[$];
        int               mismatches;

        function new();
            cfg.packet_size          = 11'd512;
            cfg.endpoint_open        = 1'b1;
            cfg.throttle_enable      = 1'b0;
            cfg.throttle_interval_ms = 16'd5000;
            foreach (slot_len[i]) slot_len[i] = '0;
            head       = '0;
            tail       = '0;
            fill       = '0;
            in_flight  = 1'b0;
            send_off   = '0;
            send_len   = '0;
            last_sent  = '0;
            accept_now = 1'b0;
            done_now   = 1'b0;
            mismatches = 0;
        endfunction

        function void emit_beat(logic [2:0] kind, logic [1:0] status, logic [1:0] src,
                                logic [1:0] slot, logic [14:0] off, logic [10:0] len,
                                logic [2:0] pend);
            bfq_pkg::t_result b;
            if (step_beats.size() >= 3) return;
            b.kind          = kind;
            b.status        = status;
            b.load_source   = src;
            b.slot          = slot;
            b.packet_offset = off;
            b.packet_length = len;
            b.frame_done    = done_now;
            b.pending       = pend;
            b.last          = 1'b0;
            step_beats.push_back(b);
        endfunction

        // Open a frame on the endpoint, or answer busy when it is closed or a frame is in flight
        function void start_frame(logic [1:0] src, logic [1:0] slot, logic [15:0] length);
            logic [10:0] pkt;
            if (!cfg.endpoint_open || in_flight) begin
                emit_beat(bfq_pkg::KIND_STATUS, bfq_pkg::ST_BUSY, bfq_pkg::SRC_NONE, slot,
                          '0, '0, '0);
                return;
            end
            send_len  = length;
            send_off  = '0;
            pkt       = ({5'd0, cfg.packet_size} < length) ? cfg.packet_size : length[10:0];
            in_flight = accept_now;
            emit_beat(bfq_pkg::KIND_TX, accept_now ? bfq_pkg::ST_OK : bfq_pkg::ST_FAIL,
                      src, slot, '0, pkt, '0);
        endfunction

        // Start the oldest queued frame when the endpoint is idle
        function void drain_ring();
            logic [1:0] s;
            if (fill == 0 || in_flight) return;
            s    = head;
            head = head + 2'd1;
            fill = fill - 3'd1;
            start_frame(bfq_pkg::SRC_SLOT, s, slot_len[s]);
        endfunction

        function void note_item(bfq_pkg::t_item it);
            logic [31:0]      elapsed;
            logic             drop;
            logic [16:0]      rem;
            logic [10:0]      pkt;
            logic [2:0]       was;
            bfq_pkg::t_result b;
            step_beats.delete();
            accept_now = it.tx_accept;
            done_now   = 1'b0;
            case (it.op)
                bfq_pkg::OP_SUBMIT: begin
                    if (it.frame_length == 0 || it.frame_length > MAX_FRAME_BYTES) begin
                        emit_beat(bfq_pkg::KIND_STATUS, bfq_pkg::ST_FAIL,
                                  bfq_pkg::SRC_NONE, '0, '0, '0, '0);
                    end else begin
                        drop = 1'b0;
                        if (cfg.throttle_enable) begin
                            elapsed = (last_sent != 0) ? it.now_ms - last_sent
                                                       : {16'd0, cfg.throttle_interval_ms};
                            if (elapsed < {16'd0, cfg.throttle_interval_ms}) drop = 1'b1;
                            else last_sent = it.now_ms;
                        end
                        if (drop) begin
                            emit_beat(bfq_pkg::KIND_STATUS, bfq_pkg::ST_OK,
                                      bfq_pkg::SRC_NONE, '0, '0, '0, '0);
                        end else if (fill == 0 && !in_flight) begin
                            start_frame(bfq_pkg::SRC_INPUT, 2'd0, it.frame_length);
                        end else begin
                            drain_ring();
                            if (fill >= QUEUE_DEPTH) begin
                                emit_beat(bfq_pkg::KIND_STATUS, bfq_pkg::ST_FAIL,
                                          bfq_pkg::SRC_NONE, '0, '0, '0, '0);
                            end else begin
                                slot_len[tail] = it.frame_length;
                                emit_beat(bfq_pkg::KIND_STORE, bfq_pkg::ST_OK,
                                          bfq_pkg::SRC_NONE, tail, '0, '0, '0);
                                tail = tail + 2'd1;
                                fill = fill + 3'd1;
                            end
                        end
                    end
                end
                bfq_pkg::OP_EVENT: begin
                    if (in_flight) begin
                        send_off = send_off + {6'd0, cfg.packet_size};
                        if (send_off < {1'b0, send_len}) begin
                            rem = {1'b0, send_len} - send_off;
                            pkt = ({6'd0, cfg.packet_size} < rem) ? cfg.packet_size
                                                                 : rem[10:0];
                            emit_beat(bfq_pkg::KIND_TX,
                                      accept_now ? bfq_pkg::ST_OK : bfq_pkg::ST_FAIL,
                                      bfq_pkg::SRC_NONE, '0, send_off[14:0], pkt, '0);
                            // Rejected mid-frame: fall back to the next queued frame
                            if (!accept_now) begin
                                in_flight = 1'b0;
                                drain_ring();
                            end
                        end else begin
                            in_flight = 1'b0;
                            done_now  = 1'b1;
                            if (fill != 0) drain_ring();
                            else emit_beat(bfq_pkg::KIND_STATUS, bfq_pkg::ST_OK,
                                           bfq_pkg::SRC_NONE, '0, '0, '0, '0);
                        end
                    end else begin
                        emit_beat(bfq_pkg::KIND_ZLP,
                                  accept_now ? bfq_pkg::ST_OK : bfq_pkg::ST_FAIL,
                                  bfq_pkg::SRC_NONE, '0, '0, '0, '0);
                    end
                end
                bfq_pkg::OP_FLUSH: begin
                    was       = fill;
                    head      = '0;
                    tail      = '0;
                    fill      = '0;
                    in_flight = 1'b0;
                    send_off  = '0;
                    send_len  = '0;
                    emit_beat(bfq_pkg::KIND_FLUSH, bfq_pkg::ST_OK, bfq_pkg::SRC_NONE,
                              '0, '0, '0, was);
                end
                default: ;
            endcase
            // Mark the final beat of the item and queue them all
            foreach (step_beats[i]) begin
                b      = step_beats[i];
                b.last = (i == step_beats.size() - 1);
                expected_beats.push_back(b);
            end
        endfunction

        function string beat_text(bfq_pkg::t_result b);
            return $sformatf("kind=%0d st=%0d src=%0d slot=%0d off=%0d len=%0d done=%0b pend=%0d last=%0b",
                             b.kind, b.status, b.load_source, b.slot, b.packet_offset,
                             b.packet_length, b.frame_done, b.pending, b.last);
        endfunction

        function void check_beat(bfq_pkg::t_result got);
            bfq_pkg::t_result want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %s", beat_text(got));
                return;
            end
            want = expected_beats.pop_front();
            if (got.kind !== want.kind || got.status !== want.status ||
                got.load_source !== want.load_source || got.slot !== want.slot ||
                got.packet_offset !== want.packet_offset ||
                got.packet_length !== want.packet_length ||
                got.frame_done !== want.frame_done || got.pending !== want.pending ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("beat mismatch at %0t", $realtime);
                    $display("  expected %s", beat_text(want));
                    $display("  actual   %s", beat_text(got));
                end
            end
        endfunction
    endclass

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    bfq_pkg::t_item   i_item  = '0;
    logic             push    = 1'b0;
    logic             full;
    bfq_pkg::t_result o_result;
    logic             empty;
    logic             pop     = 1'b0;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [3:0]       paddr   = '0;
    logic [31:0]      pwdata  = '0;
    logic [31:0]      prdata;
    logic             pready;

    bfq_scoreboard sb;
    logic          no_idle  = 1'b0;
    logic          hold_go  = 1'b0;
    logic          hold_on  = 1'b0;
    logic [31:0]   clock_ms = '0;
    int            rx_stall = 0;
    int            cycle_count = 0;

    bulk_frame_queue_packetizer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .push     (push),
        .full     (full),
        .o_result (o_result),
        .empty    (empty),
        .pop      (pop),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 i_clk = ~i_clk;

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 9);
        if (no_idle || r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Take result beats and stall the result side at random
    always @(posedge i_clk) begin
        if (i_rst_n && pop && empty === 1'b0) sb.check_beat(o_result);
        if (rx_stall > 0) begin
            rx_stall = rx_stall - 1;
            pop <= 1'b0;
        end else if (hold_on) begin
            pop <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_stall = gap_len();
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Hold off the result side for a long stretch so the block backs up
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    function automatic bfq_pkg::t_item item_of(logic [1:0] op, logic [15:0] len,
                                               logic [31:0] now, logic acc);
        bfq_pkg::t_item it;
        it.op           = op;
        it.frame_length = len;
        it.now_ms       = now;
        it.tx_accept    = acc;
        return it;
    endfunction

    // Mostly well-formed submits and completions, some flushes and junk
    function automatic bfq_pkg::t_item random_item();
        bfq_pkg::t_item it;
        int             r;
        int             cap;
        r   = $urandom_range(0, 99);
        cap = 4 * sb.cfg.packet_size;
        if (cap > MAX_FRAME_BYTES) cap = MAX_FRAME_BYTES;
        if (cap < 1) cap = 1;
        if ($urandom_range(0, 15) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(0, 800);
        it.now_ms       = clock_ms;
        it.tx_accept    = ($urandom_range(0, 7) != 0);
        it.frame_length = 16'($urandom_range(0, 65535));
        if (r < 44) begin
            it.op = bfq_pkg::OP_SUBMIT;
            if ($urandom_range(0, 9) != 0) it.frame_length = 16'($urandom_range(1, cap));
        end else if (r < 88) begin
            it.op = bfq_pkg::OP_EVENT;
        end else if (r < 94) begin
            it.op = bfq_pkg::OP_FLUSH;
        end else if (r < 97) begin
            it.op = OP_UNUSED;
        end else begin
            it.op = bfq_pkg::OP_SUBMIT;
            it.frame_length = ($urandom_range(0, 1) == 0) ? 16'd0
                                                          : 16'($urandom_range(32769, 65535));
        end
        return it;
    endfunction

    // Offer one beat, hold it until taken, then maybe idle
    task automatic send_item(input bfq_pkg::t_item it);
        int g;
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full !== 1'b0);
        sb.note_item(it);
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Drop push and wait for every expected beat, then let the pipeline settle
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            bfq_pkg::REG_PACKET_SIZE: sb.cfg.packet_size          = val[10:0];
            bfq_pkg::REG_EP_OPEN:     sb.cfg.endpoint_open        = val[0];
            bfq_pkg::REG_THR_EN:      sb.cfg.throttle_enable      = val[0];
            bfq_pkg::REG_THR_INTV:    sb.cfg.throttle_interval_ms = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    initial begin
        int ps;
        int open;
        int thr;
        int intv;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default settings: idle completions, bad lengths, ring fill and overflow
        send_item(item_of(bfq_pkg::OP_EVENT, 16'd0, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_EVENT, 16'd0, 32'd0, 1'b0));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd0, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd32769, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd32768, 32'hFFFF_FFFF, 1'b1));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd1, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd700, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd20, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd30, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd40, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_EVENT, 16'hFFFF, 32'd0, 1'b0));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd50, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_EVENT, 16'd0, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_EVENT, 16'd0, 32'd0, 1'b1));
        send_item(item_of(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        send_item(item_of(bfq_pkg::OP_FLUSH, 16'd0, 32'd0, 1'b0));
        wait_idle();

        // Zero packet size: the frame only ends on flush
        write_reg(bfq_pkg::REG_PACKET_SIZE, 32'd0);
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd100, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_EVENT, 16'd0, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_FLUSH, 16'd0, 32'd0, 1'b1));
        wait_idle();

        // Throttling: pass, drop, pass at the interval, then queue one frame
        write_reg(bfq_pkg::REG_PACKET_SIZE, 32'd1024);
        write_reg(bfq_pkg::REG_THR_EN, 32'd1);
        write_reg(bfq_pkg::REG_THR_INTV, 32'd1000);
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd300, 32'd5000, 1'b1));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd300, 32'd5500, 1'b1));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd250, 32'd6000, 1'b1));
        wait_idle();

        // Closed endpoint: the queued frame is lost, a new one gets busy
        write_reg(bfq_pkg::REG_EP_OPEN, 32'd0);
        send_item(item_of(bfq_pkg::OP_EVENT, 16'd0, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_SUBMIT, 16'd10, 32'd0, 1'b1));
        send_item(item_of(bfq_pkg::OP_FLUSH, 16'd0, 32'd0, 1'b1));

        // Random phases, each under its own settings
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                0: begin ps = 1;    open = 1; thr = 0; intv = 0;     end
                1: begin ps = 1024; open = 1; thr = 1; intv = 65535; end
                default: begin
                    ps   = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                       : $urandom_range(1, 1024);
                    open = ($urandom_range(0, 5) != 0) ? 1 : 0;
                    thr  = $urandom_range(0, 1);
                    intv = $urandom_range(0, 3000);
                end
            endcase
            write_reg(bfq_pkg::REG_PACKET_SIZE, ps);
            write_reg(bfq_pkg::REG_EP_OPEN, open);
            write_reg(bfq_pkg::REG_THR_EN, thr);
            write_reg(bfq_pkg::REG_THR_INTV, intv);
            no_idle = (ph == 3);
            if (ph == 1) hold_go = 1'b1;
            for (int k = 0; k < 50; k++) send_item(random_item());
        end
        no_idle = 1'b0;
        wait_idle();

        if (sb.expected_beats.size() != 0)
            $display("%0d expected beats never arrived", sb.expected_beats.size());
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== bulk_frame_queue_packetizer.f =====
src/bfq_pkg.sv
src/bfq_front.sv
src/bfq_back.sv
src/bulk_frame_queue_packetizer.sv
src/bfq_checker.sv
bench/bulk_frame_queue_packetizer_tb.sv
